// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dts assertion failed");

// condition in one cycle implies a consequence in the next cycle
`define DTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dts assertion failed");

`endif

// File: hw/rtl/dts_pkg.sv
// package for the dfs topological sort: sizes, microcode types and control store
`default_nettype none

package dts_pkg;

  // default sizes and the fixed vertex field width
  localparam int DTS_MAX_VERTICES = 64;
  localparam int DTS_MAX_EDGES    = 1024;
  localparam int VERT_W           = 7;
  localparam logic [VERT_W-1:0] VCOUNT_RST = VERT_W'(64);

  // request action codes
  localparam logic ACTION_ADD = 1'b0;
  localparam logic ACTION_RUN = 1'b1;

  // microprogram step addresses
  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_ADD    = 4'd1,
    ST_INIT   = 4'd2,
    ST_OUTER  = 4'd3,
    ST_PICK   = 4'd4,
    ST_LDHEAD = 4'd5,
    ST_EXAM   = 4'd6,
    ST_FINV   = 4'd7,
    ST_NEXTS  = 4'd8,
    ST_POPLD  = 4'd9,
    ST_EDGE   = 4'd10,
    ST_EMIT   = 4'd11,
    ST_EMITRD = 4'd12,
    ST_EMITLD = 4'd13,
    ST_CLEAR  = 4'd14
  } step_t;

  // datapath actions
  typedef enum logic [3:0] {
    A_NONE,
    A_IDLE,
    A_ADD,
    A_INIT,
    A_PICK,
    A_LDHEAD,
    A_FINV,
    A_DECS,
    A_POP,
    A_EDGE,
    A_EMITLD,
    A_CLEAR
  } act_t;

  // branch conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_S_ZERO,
    C_SEEN_S,
    C_P_NULL,
    C_TOP_ONE,
    C_SEEN_W,
    C_DONE_ZERO,
    C_OUT_FREE
  } cond_t;

  // one control word
  typedef struct packed {
    act_t  act;
    cond_t cond;
    logic  disp;   // add the request action bit to the taken target
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  // control store
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{act: A_NONE, cond: C_ALWAYS, disp: 1'b0, tgt_t: ST_IDLE, tgt_f: ST_IDLE};
    case (s)
      ST_IDLE:   w = '{A_IDLE,   C_ACCEPT,    1'b1, ST_ADD,    ST_IDLE};
      ST_ADD:    w = '{A_ADD,    C_ALWAYS,    1'b0, ST_IDLE,   ST_IDLE};
      ST_INIT:   w = '{A_INIT,   C_ALWAYS,    1'b0, ST_OUTER,  ST_OUTER};
      ST_OUTER:  w = '{A_NONE,   C_S_ZERO,    1'b0, ST_EMIT,   ST_PICK};
      ST_PICK:   w = '{A_PICK,   C_SEEN_S,    1'b0, ST_OUTER,  ST_LDHEAD};
      ST_LDHEAD: w = '{A_LDHEAD, C_ALWAYS,    1'b0, ST_EXAM,   ST_EXAM};
      ST_EXAM:   w = '{A_NONE,   C_P_NULL,    1'b0, ST_FINV,   ST_EDGE};
      ST_FINV:   w = '{A_FINV,   C_TOP_ONE,   1'b0, ST_NEXTS,  ST_POPLD};
      ST_NEXTS:  w = '{A_DECS,   C_ALWAYS,    1'b0, ST_OUTER,  ST_OUTER};
      ST_POPLD:  w = '{A_POP,    C_ALWAYS,    1'b0, ST_EXAM,   ST_EXAM};
      ST_EDGE:   w = '{A_EDGE,   C_SEEN_W,    1'b0, ST_EXAM,   ST_LDHEAD};
      ST_EMIT:   w = '{A_NONE,   C_DONE_ZERO, 1'b0, ST_CLEAR,  ST_EMITRD};
      ST_EMITRD: w = '{A_NONE,   C_OUT_FREE,  1'b0, ST_EMITLD, ST_EMITRD};
      ST_EMITLD: w = '{A_EMITLD, C_ALWAYS,    1'b0, ST_EMIT,   ST_EMIT};
      ST_CLEAR:  w = '{A_CLEAR,  C_ALWAYS,    1'b0, ST_IDLE,   ST_IDLE};
      default:   w = '{A_NONE,   C_ALWAYS,    1'b0, ST_IDLE,   ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dfs_topological_sort.sv
// dfs topological sort: edge store, microcoded depth-first search and order output
`default_nettype none
`include "assert_macros.svh"

// Edge requests (in_action 0) add src->dst to the head of src's adjacency list;
// a request with a vertex of 0 or above MAX_VERTICES is ignored, and one that
// arrives with the store full is dropped and raises out_edge_overflow on the
// next run. An edge request passes through the accept step and then the store
// write step. A run request (in_action 1) does a depth-first search from
// vertex cfg vertex_count down to 1 and returns the vertices reached in reverse
// finishing order, one result per vertex, with out_last on the final one; it
// then empties the edge store. The run is driven by a microprogram that issues
// one control word per cycle against memories with one read and one write port,
// and it waits whenever the output side stalls. cfg_we should only be raised
// while no request is in progress.
module dfs_topological_sort
  import dts_pkg::*;
#(
  parameter int MAX_VERTICES = DTS_MAX_VERTICES,
  parameter int MAX_EDGES    = DTS_MAX_EDGES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [VERT_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_action,
  input  wire logic [VERT_W-1:0] in_src_vertex,
  input  wire logic [VERT_W-1:0] in_dst_vertex,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [VERT_W-1:0]      out_order_vertex,
  output logic                   out_last,
  output logic                   out_edge_overflow
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EA  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam logic [EW-1:0]     NULL_P = EW'(MAX_EDGES);
  localparam logic [VCW-1:0]    VMAX   = VCW'(MAX_VERTICES);
  localparam logic [VERT_W-1:0] VLIM   = VERT_W'(MAX_VERTICES);

  typedef struct packed {
    logic [VW-1:0] v;
    logic [EW-1:0] p;
  } frame_t;

  // memories
  logic [EW-1:0] head_mem [MAX_VERTICES];
  logic [VW-1:0] etgt_mem [MAX_EDGES];
  logic [EW-1:0] elnk_mem [MAX_EDGES];
  frame_t        stk_mem  [MAX_VERTICES];
  logic [VW-1:0] fin_mem  [MAX_VERTICES];

  // sequencer and control registers
  step_t                   upc_r, upc_nxt;
  logic [VERT_W-1:0]       vcount_r, vcount_nxt;
  logic [EW-1:0]           edges_r, edges_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [MAX_VERTICES-1:0] head_vld_r, head_vld_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [VCW-1:0]          top_r, top_nxt;
  logic [VCW-1:0]          done_r, done_nxt;
  logic [VCW-1:0]          s_r, s_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // datapath registers
  logic [VERT_W-1:0] src_r, src_nxt;
  logic [VERT_W-1:0] dst_r, dst_nxt;
  logic [VW-1:0]     cur_v_r, cur_v_nxt;
  logic [EW-1:0]     cur_p_r, cur_p_nxt;
  logic [VERT_W-1:0] out_vertex_r;
  logic              out_last_r, out_ovf_r;

  // registered memory read data
  logic [EW-1:0] head_rd_r;
  logic          head_rv_r;
  logic [VW-1:0] etgt_rd_r;
  logic [EW-1:0] elnk_rd_r;
  frame_t        stk_rd_r;
  logic [VW-1:0] fin_rd_r;

  // memory control
  logic [VW-1:0] head_raddr, head_waddr;
  logic [EW-1:0] head_wdata;
  logic          head_we, edge_we, stk_we, fin_we;

  uword_t            uw;
  logic              taken;
  logic [VCW-1:0]    s_m1, top_m1, top_m2, done_m1, n_start;
  logic [VW-1:0]     s_idx;
  logic [VERT_W-1:0] src_m1, dst_m1, in_src_m1;
  logic              src_ok, dst_ok;

  assign uw        = ucode(upc_r);
  assign s_m1      = s_r - VCW'(1);
  assign s_idx     = s_m1[VW-1:0];
  assign top_m1    = top_r - VCW'(1);
  assign top_m2    = top_r - VCW'(2);
  assign done_m1   = done_r - VCW'(1);
  assign src_m1    = src_r - VERT_W'(1);
  assign dst_m1    = dst_r - VERT_W'(1);
  assign in_src_m1 = in_src_vertex - VERT_W'(1);
  assign src_ok    = (src_r != '0) && (src_r <= VLIM);
  assign dst_ok    = (dst_r != '0) && (dst_r <= VLIM);
  assign n_start   = (vcount_r > VLIM) ? VMAX : VCW'(vcount_r);

  // branch condition select
  always_comb begin
    case (uw.cond)
      C_ALWAYS:    taken = 1'b1;
      C_ACCEPT:    taken = in_valid;
      C_S_ZERO:    taken = (s_r == '0);
      C_SEEN_S:    taken = visited_r[s_idx];
      C_P_NULL:    taken = (cur_p_r >= NULL_P);
      C_TOP_ONE:   taken = (top_r == VCW'(1));
      C_SEEN_W:    taken = visited_r[etgt_rd_r] || (top_r >= VMAX);
      C_DONE_ZERO: taken = (done_r == '0);
      C_OUT_FREE:  taken = !out_valid_r || out_ready;
      default:     taken = 1'b1;
    endcase
  end

  // step counter with dispatch on the request action
  always_comb begin
    if (!taken) begin
      upc_nxt = uw.tgt_f;
    end else if (uw.disp) begin
      upc_nxt = step_t'(uw.tgt_t + {3'd0, in_action});
    end else begin
      upc_nxt = uw.tgt_t;
    end
  end

  assign in_ready = (upc_r == ST_IDLE);

  // datapath actions
  always_comb begin
    vcount_nxt    = cfg_we ? cfg_wdata : vcount_r;
    edges_nxt     = edges_r;
    ovf_nxt       = ovf_r;
    head_vld_nxt  = head_vld_r;
    visited_nxt   = visited_r;
    top_nxt       = top_r;
    done_nxt      = done_r;
    s_nxt         = s_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    cur_v_nxt     = cur_v_r;
    cur_p_nxt     = cur_p_r;
    out_valid_nxt = out_valid_r && !out_ready;
    head_raddr    = in_src_m1[VW-1:0];
    head_waddr    = src_m1[VW-1:0];
    head_wdata    = edges_r;
    head_we       = 1'b0;
    edge_we       = 1'b0;
    stk_we        = 1'b0;
    fin_we        = 1'b0;
    case (uw.act)
      A_IDLE: begin
        if (taken) begin
          src_nxt = in_src_vertex;
          dst_nxt = in_dst_vertex;
        end
      end
      A_ADD: begin
        if (src_ok && dst_ok) begin
          if (edges_r >= NULL_P) begin
            ovf_nxt = 1'b1;
          end else begin
            edge_we                     = 1'b1;
            head_we                     = 1'b1;
            head_vld_nxt[src_m1[VW-1:0]] = 1'b1;
            edges_nxt                   = edges_r + EW'(1);
          end
        end
      end
      A_INIT: begin
        visited_nxt = '0;
        s_nxt       = n_start;
        done_nxt    = '0;
      end
      A_PICK: begin
        head_raddr = s_idx;
        if (taken) begin
          s_nxt = s_m1;
        end else begin
          visited_nxt[s_idx] = 1'b1;
          cur_v_nxt          = s_idx;
          top_nxt            = VCW'(1);
        end
      end
      A_LDHEAD: begin
        cur_p_nxt = head_rv_r ? head_rd_r : NULL_P;
      end
      A_FINV: begin
        if (done_r < VMAX) begin
          fin_we   = 1'b1;
          done_nxt = done_r + VCW'(1);
        end
        top_nxt = top_m1;
      end
      A_DECS: begin
        s_nxt = s_m1;
      end
      A_POP: begin
        cur_v_nxt = stk_rd_r.v;
        cur_p_nxt = stk_rd_r.p;
      end
      A_EDGE: begin
        head_raddr = etgt_rd_r;
        if (taken) begin
          cur_p_nxt = elnk_rd_r;
        end else begin
          stk_we                 = 1'b1;
          visited_nxt[etgt_rd_r] = 1'b1;
          cur_v_nxt              = etgt_rd_r;
          top_nxt                = top_r + VCW'(1);
        end
      end
      A_EMITLD: begin
        out_valid_nxt = 1'b1;
        done_nxt      = done_m1;
      end
      A_CLEAR: begin
        head_vld_nxt = '0;
        edges_nxt    = '0;
        ovf_nxt      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= ST_IDLE;
      vcount_r    <= VCOUNT_RST;
      edges_r     <= '0;
      ovf_r       <= 1'b0;
      head_vld_r  <= '0;
      visited_r   <= '0;
      top_r       <= '0;
      done_r      <= '0;
      s_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      vcount_r    <= vcount_nxt;
      edges_r     <= edges_nxt;
      ovf_r       <= ovf_nxt;
      head_vld_r  <= head_vld_nxt;
      visited_r   <= visited_nxt;
      top_r       <= top_nxt;
      done_r      <= done_nxt;
      s_r         <= s_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    cur_v_r <= cur_v_nxt;
    cur_p_r <= cur_p_nxt;
    if (uw.act == A_EMITLD) begin
      out_vertex_r <= VERT_W'(fin_rd_r) + VERT_W'(1);
      out_last_r   <= (done_r == VCW'(1));
      out_ovf_r    <= ovf_r;
    end
  end

  // list head memory
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_r <= head_mem[head_raddr];
    head_rv_r <= head_vld_r[head_raddr];
  end

  // edge store memories
  always_ff @(posedge clk) begin
    if (edge_we) begin
      etgt_mem[edges_r[EA-1:0]] <= dst_m1[VW-1:0];
      elnk_mem[edges_r[EA-1:0]] <= head_rv_r ? head_rd_r : NULL_P;
    end
    etgt_rd_r <= etgt_mem[cur_p_r[EA-1:0]];
    elnk_rd_r <= elnk_mem[cur_p_r[EA-1:0]];
  end

  // walk stack: frames below the top one, which stays in cur_v_r/cur_p_r
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[top_m1[VW-1:0]] <= '{v: cur_v_r, p: elnk_rd_r};
    end
    stk_rd_r <= stk_mem[top_m2[VW-1:0]];
  end

  // finishing order memory
  always_ff @(posedge clk) begin
    if (fin_we) begin
      fin_mem[done_r[VW-1:0]] <= cur_v_r;
    end
    fin_rd_r <= fin_mem[done_m1[VW-1:0]];
  end

  assign out_valid         = out_valid_r;
  assign out_order_vertex  = out_vertex_r;
  assign out_last          = out_last_r;
  assign out_edge_overflow = out_ovf_r;

  // checks
  `DTS_ASSERT(a_top_bound, clk, rst_n, top_r <= VMAX)
  `DTS_ASSERT(a_done_bound, clk, rst_n, done_r <= VMAX)
  `DTS_ASSERT(a_idle_stack_empty, clk, rst_n, (upc_r != ST_IDLE) || (top_r == '0))
  `DTS_ASSERT_NEXT(a_result_from_emit, clk, rst_n, !out_valid_r && (uw.act != A_EMITLD), !out_valid_r)

endmodule

`default_nettype wire
